[sv/srat_pkg.sv]
// ----------------------------------------------------------------------------
// srat_pkg - shared constants and types for the sensor running-average table
// Table sizes, ring constants, reciprocal for the averaging divide and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package srat_pkg;

    localparam int MAX_SENSORS = 16;
    localparam int RING_LEN    = 5;

    localparam int SLOT_W    = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;
    localparam int CNT_W     = $clog2(MAX_SENSORS + 1);
    localparam int PTR_W     = (RING_LEN > 1) ? $clog2(RING_LEN) : 1;
    localparam int RING_DEPTH = MAX_SENSORS * RING_LEN;
    localparam int RADDR_W   = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

    localparam int TEMP_W = 16;
    localparam int ID_W   = 16;
    localparam int ROOM_W = 16;
    localparam int TIME_W = 32;

    // ring sum and its magnitude
    localparam int SUM_W = TEMP_W + 1 + $clog2(RING_LEN + 1);
    localparam int MAG_W = SUM_W - 1;

    // divide by RING_LEN as multiply by a rounded-up reciprocal; exact for
    // magnitudes below 2**RECIP_SH / RING_LEN
    localparam int RECIP_SH = 24;
    localparam int RECIP_W  = RECIP_SH + 1;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((2 ** RECIP_SH) + RING_LEN - 1) / RING_LEN);
    localparam int PROD_W = MAG_W + RECIP_W;

    localparam logic signed [TEMP_W-1:0] FILL_VAL    = -16'sd30000;
    localparam logic signed [TEMP_W-1:0] VALID_FLOOR = -16'sd27500;

    // configuration port
    localparam int CFG_AW = 3;
    localparam int CFG_DW = 32;
    localparam logic signed [TEMP_W-1:0] MIN_TEMP_RST = 16'sd1000;
    localparam logic signed [TEMP_W-1:0] MAX_TEMP_RST = 16'sd3000;
    localparam logic REG_MIN_TEMP = 1'b0;
    localparam logic REG_MAX_TEMP = 1'b1;

    localparam logic REQ_MAP    = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    typedef struct packed {
        logic capture;  // latch the incoming request
        logic search;   // id lookup / map append
        logic fill;     // write one sentinel into the new ring
        logic write;    // pointer advance and sample write
        logic rd;       // issue one ring read
        logic mag;      // sign, magnitude and threshold flags
        logic mul;      // reciprocal multiply
        logic load;     // load the result register
    } t_cmd;

    typedef struct packed {
        logic is_map;
        logic full;
        logic hit;
        logic k_last;
    } t_stat;

endpackage

[sv/srat_ctrl.sv]
// ----------------------------------------------------------------------------
// srat_ctrl - sequencer for the sensor running-average table
// One-hot state machine stepping a request through lookup, ring update,
// ring sum and averaging; owns the request and result handshakes.
// ----------------------------------------------------------------------------
module srat_ctrl
    import srat_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_out_stall,
    input  t_stat i_stat,
    output logic  o_in_stall,
    output logic  o_out_valid,
    output t_cmd  o_cmd
);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_SEARCH = 9'b000000010,
        S_FILL   = 9'b000000100,
        S_WRITE  = 9'b000001000,
        S_READ   = 9'b000010000,
        S_ACC    = 9'b000100000,
        S_MAG    = 9'b001000000,
        S_MUL    = 9'b010000000,
        S_FINISH = 9'b100000000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_out_free;

    assign w_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_SEARCH;
                end
            end
            S_SEARCH: begin
                o_cmd.search = 1'b1;
                if (i_stat.is_map) begin
                    n_state = i_stat.full ? S_IDLE : S_FILL;
                end else begin
                    // a miss skips the ring and averages a zero sum
                    n_state = i_stat.hit ? S_WRITE : S_MAG;
                end
            end
            S_FILL: begin
                o_cmd.fill = 1'b1;
                if (i_stat.k_last) begin
                    n_state = S_IDLE;
                end
            end
            S_WRITE: begin
                o_cmd.write = 1'b1;
                n_state     = S_READ;
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                if (i_stat.k_last) begin
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                // last read word is summed in this cycle
                n_state = S_MAG;
            end
            S_MAG: begin
                o_cmd.mag = 1'b1;
                n_state   = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_FINISH;
            end
            S_FINISH: begin
                if (w_out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

[sv/srat_dp.sv]
// ----------------------------------------------------------------------------
// srat_dp - datapath of the sensor running-average table
// Entry table, sample ring memory, ring accumulator, reciprocal divide,
// threshold compare and the result register.
// ----------------------------------------------------------------------------
module srat_dp
    import srat_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cmd                     i_cmd,
    output t_stat                    o_stat,
    input  logic signed [TEMP_W-1:0] i_min_temp,
    input  logic signed [TEMP_W-1:0] i_max_temp,
    input  logic                     i_req_type,
    input  logic [ID_W-1:0]          i_probe_id,
    input  logic [ROOM_W-1:0]        i_room_id,
    input  logic signed [TEMP_W-1:0] i_sample_value,
    input  logic [TIME_W-1:0]        i_timestamp,
    output logic                     o_found,
    output logic [ROOM_W-1:0]        o_room_of_sensor,
    output logic signed [TEMP_W-1:0] o_average,
    output logic [TIME_W-1:0]        o_last_time,
    output logic                     o_too_warm,
    output logic                     o_too_cold,
    output logic [CNT_W-1:0]         o_sensor_count
);

    // captured request
    logic                     r_req;
    logic [ID_W-1:0]          r_id;
    logic [ROOM_W-1:0]        r_room;
    logic signed [TEMP_W-1:0] r_sample;
    logic [TIME_W-1:0]        r_ts;

    // entry table
    logic [ID_W-1:0]   r_key  [MAX_SENSORS];
    logic [ROOM_W-1:0] r_rooms[MAX_SENSORS];
    logic [TIME_W-1:0] r_times[MAX_SENSORS];
    logic [PTR_W-1:0]  r_ptr  [MAX_SENSORS];
    logic [CNT_W-1:0]  r_count;

    // sample ring memory
    logic signed [TEMP_W-1:0] r_ring[RING_DEPTH];
    logic signed [TEMP_W-1:0] r_rd_data;
    logic                     r_rd_vld;

    logic               r_hit;
    logic [SLOT_W-1:0]  r_slot;
    logic [RADDR_W-1:0] r_base;
    logic [PTR_W-1:0]   r_k;

    logic signed [SUM_W-1:0] r_sum;
    logic [MAG_W-1:0]        r_mag;
    logic                    r_neg;
    logic                    r_warm;
    logic                    r_cold;
    logic [PROD_W-1:0]       r_prod;

    // result register
    logic                     r_found;
    logic [ROOM_W-1:0]        r_out_room;
    logic signed [TEMP_W-1:0] r_avg;
    logic [TIME_W-1:0]        r_out_time;
    logic                     r_out_warm;
    logic                     r_out_cold;
    logic [CNT_W-1:0]         r_out_count;

    logic                    w_hit;
    logic [SLOT_W-1:0]       w_slot;
    logic [SLOT_W-1:0]       w_new_slot;
    logic                    w_full;
    logic [PTR_W-1:0]        w_next_ptr;
    logic [RADDR_W-1:0]      w_wr_addr;
    logic [RADDR_W-1:0]      w_rd_addr;
    logic signed [SUM_W-1:0] w_min_lim;
    logic signed [SUM_W-1:0] w_max_lim;
    logic signed [SUM_W-1:0] w_neg_sum;
    logic [TEMP_W-1:0]       w_quot;

    // first live entry with a matching key wins
    always_comb begin
        w_hit  = 1'b0;
        w_slot = '0;
        for (int i = MAX_SENSORS - 1; i >= 0; i--) begin
            if ((CNT_W'(i) < r_count) && (r_key[i] == r_id)) begin
                w_hit  = 1'b1;
                w_slot = SLOT_W'(i);
            end
        end
    end

    assign w_full     = (r_count == CNT_W'(MAX_SENSORS));
    assign w_new_slot = r_count[SLOT_W-1:0];
    assign w_next_ptr = (r_ptr[r_slot] == PTR_W'(RING_LEN - 1)) ? '0
                                                                : r_ptr[r_slot] + 1'b1;
    assign w_wr_addr  = i_cmd.fill ? r_base + RADDR_W'(r_k)
                                   : r_base + RADDR_W'(w_next_ptr);
    assign w_rd_addr  = r_base + RADDR_W'(r_k);

    assign w_min_lim = SUM_W'(i_min_temp) * SUM_W'(RING_LEN);
    assign w_max_lim = SUM_W'(i_max_temp) * SUM_W'(RING_LEN);
    assign w_neg_sum = -r_sum;
    assign w_quot    = r_prod[RECIP_SH +: TEMP_W];

    assign o_stat.is_map = (r_req == REQ_MAP);
    assign o_stat.full   = w_full;
    assign o_stat.hit    = w_hit;
    assign o_stat.k_last = (r_k == PTR_W'(RING_LEN - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.search && (r_req == REQ_MAP) && !w_full) begin
            r_count <= r_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req    <= i_req_type;
            r_id     <= i_probe_id;
            r_room   <= i_room_id;
            r_sample <= i_sample_value;
            r_ts     <= i_timestamp;
        end

        if (i_cmd.search) begin
            r_k   <= '0;
            r_sum <= '0;
            if (r_req == REQ_MAP) begin
                r_base <= RADDR_W'(r_count * RING_LEN);
                if (!w_full) begin
                    r_key[w_new_slot]   <= r_id;
                    r_rooms[w_new_slot] <= r_room;
                    r_times[w_new_slot] <= '0;
                    r_ptr[w_new_slot]   <= '0;
                end
            end else begin
                r_hit  <= w_hit;
                r_slot <= w_slot;
                r_base <= RADDR_W'(w_slot * RING_LEN);
            end
        end else if (i_cmd.fill || i_cmd.rd) begin
            r_k <= r_k + 1'b1;
        end

        if (i_cmd.write) begin
            r_ptr[r_slot]   <= w_next_ptr;
            r_times[r_slot] <= r_ts;
        end

        // sentinel and anything at or below the floor add nothing
        if (r_rd_vld && (r_rd_data > VALID_FLOOR)) begin
            r_sum <= r_sum + SUM_W'(r_rd_data);
        end

        if (i_cmd.mag) begin
            r_neg  <= r_sum[SUM_W-1];
            r_mag  <= r_sum[SUM_W-1] ? w_neg_sum[MAG_W-1:0] : r_sum[MAG_W-1:0];
            r_warm <= (r_sum > w_max_lim);
            r_cold <= !(r_sum > w_max_lim) && (r_sum < w_min_lim);
        end

        if (i_cmd.mul) begin
            r_prod <= PROD_W'(r_mag) * PROD_W'(RECIP);
        end

        if (i_cmd.load) begin
            r_found     <= r_hit;
            r_out_room  <= r_hit ? r_rooms[r_slot] : '0;
            r_out_time  <= r_hit ? r_times[r_slot] : '0;
            r_avg       <= r_neg ? -$signed(w_quot) : $signed(w_quot);
            r_out_warm  <= r_warm;
            r_out_cold  <= r_cold;
            r_out_count <= r_count;
        end
    end

    // ring memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.fill) begin
            r_ring[w_wr_addr] <= FILL_VAL;
        end else if (i_cmd.write) begin
            r_ring[w_wr_addr] <= r_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rd_data <= r_ring[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.rd;
        end
    end

    assign o_found          = r_found;
    assign o_room_of_sensor = r_out_room;
    assign o_average        = r_avg;
    assign o_last_time      = r_out_time;
    assign o_too_warm       = r_out_warm;
    assign o_too_cold       = r_out_cold;
    assign o_sensor_count   = r_out_count;

endmodule

[sv/sensor_running_average_table_core.sv]
// ----------------------------------------------------------------------------
// sensor_running_average_table_core - sensor table with per-entry average
// Top level: threshold registers on the APB-style port, sequencer and
// datapath.
// ----------------------------------------------------------------------------
// Requests are taken one at a time. A map request appends to the table and
// writes one sentinel per ring slot before the next request can be taken;
// a dropped map request (table full) skips the sentinel writes.
// A sample request whose id is found steps through lookup, ring write, one
// read per ring slot, sum, magnitude, reciprocal multiply and result load;
// an unknown id goes from lookup straight to magnitude. The ring sum is built
// from the sample ring memory, read one word per cycle. A finished result
// sits in an output register, so the next request is accepted while it waits;
// a further result waits until that register is taken. Threshold registers
// min_temp (0x0) and max_temp (0x4) should be written only while idle.
// ----------------------------------------------------------------------------
module sensor_running_average_table_core
    import srat_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // request channel
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic                     i_req_type,
    input  logic [ID_W-1:0]          i_probe_id,
    input  logic [ROOM_W-1:0]        i_room_id,
    input  logic signed [TEMP_W-1:0] i_sample_value,
    input  logic [TIME_W-1:0]        i_timestamp,
    // result channel
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic                     o_found,
    output logic [ROOM_W-1:0]        o_room_of_sensor,
    output logic signed [TEMP_W-1:0] o_average,
    output logic [TIME_W-1:0]        o_last_time,
    output logic                     o_too_warm,
    output logic                     o_too_cold,
    output logic [CNT_W-1:0]         o_sensor_count,
    // configuration
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [CFG_AW-1:0]        paddr,
    input  logic [CFG_DW-1:0]        pwdata,
    output logic [CFG_DW-1:0]        prdata,
    output logic                     pready
);

    logic signed [TEMP_W-1:0] r_min_temp;
    logic signed [TEMP_W-1:0] r_max_temp;
    logic                     w_cfg_wr;
    t_cmd                     w_cmd;
    t_stat                    w_stat;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_temp <= MIN_TEMP_RST;
            r_max_temp <= MAX_TEMP_RST;
        end else if (w_cfg_wr) begin
            if (paddr[2] == REG_MIN_TEMP) begin
                r_min_temp <= $signed(pwdata[TEMP_W-1:0]);
            end else begin
                r_max_temp <= $signed(pwdata[TEMP_W-1:0]);
            end
        end
    end

    assign prdata = (paddr[2] == REG_MAX_TEMP) ? CFG_DW'(r_max_temp) : CFG_DW'(r_min_temp);

    srat_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (w_stat),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (w_cmd)
    );

    srat_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .i_min_temp       (r_min_temp),
        .i_max_temp       (r_max_temp),
        .i_req_type       (i_req_type),
        .i_probe_id       (i_probe_id),
        .i_room_id        (i_room_id),
        .i_sample_value   (i_sample_value),
        .i_timestamp      (i_timestamp),
        .o_found          (o_found),
        .o_room_of_sensor (o_room_of_sensor),
        .o_average        (o_average),
        .o_last_time      (o_last_time),
        .o_too_warm       (o_too_warm),
        .o_too_cold       (o_too_cold),
        .o_sensor_count   (o_sensor_count)
    );

endmodule
